// ===== sv/mcd_pkg.sv =====
// Shared types, constants and the code table for the Morse code decoder.
// No dependencies; used by mcd_result_fifo and morse_code_decoder.
`default_nettype none

package mcd_pkg;

    // Character codes
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // Longest code in the table
    localparam int LONGEST_CODE = 5;

    // Default depth of the symbol buffer
    localparam int MAX_SYMBOLS_DEF = 8;

    // Result queue geometry: room for two results per accepted item
    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);
    localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

    // One result item
    typedef struct packed {
        logic       line_done;
        logic [7:0] character;
    } result_t;

    // Code table lookup. Bit k of pattern is 1 when symbol k is a dash.
    function automatic logic [7:0] lookup_code(input logic [7:0] pattern,
                                               input logic [3:0] count);
        logic [5:0] mask6;
        logic [4:0] pat;
        logic [7:0] ch;
        mask6 = (6'd1 << count[2:0]) - 6'd1;
        pat   = pattern[4:0] & mask6[4:0];
        ch    = CH_QUERY;
        if (count != 4'd0 && count <= 4'(LONGEST_CODE)) begin
            case ({count[2:0], pat})
                {3'd1, 5'd0}:  ch = "E";
                {3'd1, 5'd1}:  ch = "T";
                {3'd2, 5'd0}:  ch = "I";
                {3'd2, 5'd2}:  ch = "A";
                {3'd2, 5'd1}:  ch = "N";
                {3'd2, 5'd3}:  ch = "M";
                {3'd3, 5'd0}:  ch = "S";
                {3'd3, 5'd4}:  ch = "U";
                {3'd3, 5'd2}:  ch = "R";
                {3'd3, 5'd6}:  ch = "W";
                {3'd3, 5'd1}:  ch = "D";
                {3'd3, 5'd5}:  ch = "K";
                {3'd3, 5'd3}:  ch = "G";
                {3'd3, 5'd7}:  ch = "O";
                {3'd4, 5'd0}:  ch = "H";
                {3'd4, 5'd8}:  ch = "V";
                {3'd4, 5'd4}:  ch = "F";
                {3'd4, 5'd2}:  ch = "L";
                {3'd4, 5'd6}:  ch = "P";
                {3'd4, 5'd14}: ch = "J";
                {3'd4, 5'd1}:  ch = "B";
                {3'd4, 5'd9}:  ch = "X";
                {3'd4, 5'd5}:  ch = "C";
                {3'd4, 5'd13}: ch = "Y";
                {3'd4, 5'd3}:  ch = "Z";
                {3'd4, 5'd11}: ch = "Q";
                {3'd5, 5'd0}:  ch = "5";
                {3'd5, 5'd16}: ch = "4";
                {3'd5, 5'd24}: ch = "3";
                {3'd5, 5'd28}: ch = "2";
                {3'd5, 5'd30}: ch = "1";
                {3'd5, 5'd31}: ch = "0";
                {3'd5, 5'd1}:  ch = "6";
                {3'd5, 5'd3}:  ch = "7";
                {3'd5, 5'd7}:  ch = "8";
                {3'd5, 5'd15}: ch = "9";
                default:       ch = CH_QUERY;
            endcase
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mcd_result_fifo.sv =====
// Small register queue of result items; takes up to two pushes per cycle.
// Depends on mcd_pkg for result_t and the queue geometry.
`default_nettype none

module mcd_result_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [1:0]        push_num,
    input  wire mcd_pkg::result_t  push_data0,
    input  wire mcd_pkg::result_t  push_data1,
    output logic                   room_for_two,
    input  wire logic              pop,
    output logic                   out_valid,
    output mcd_pkg::result_t       out_data
);

    mcd_pkg::result_t                  mem_reg [mcd_pkg::RES_DEPTH];
    logic [mcd_pkg::RES_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [mcd_pkg::RES_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [mcd_pkg::RES_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [mcd_pkg::RES_PTR_W-1:0]     wr_ptr_plus1;
    logic                              do_pop;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign out_valid    = (cnt_reg != '0);
    assign out_data     = mem_reg[rd_ptr_reg];
    assign do_pop       = pop && out_valid;
    assign room_for_two = (cnt_reg <= mcd_pkg::RES_CNT_W'(mcd_pkg::RES_DEPTH - 2));

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg + mcd_pkg::RES_PTR_W'(push_num);
        rd_ptr_next = rd_ptr_reg + mcd_pkg::RES_PTR_W'(do_pop);
        cnt_next    = cnt_reg + mcd_pkg::RES_CNT_W'(push_num)
                      - mcd_pkg::RES_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage: first push at the write pointer, second right after it
    always_ff @(posedge aclk) begin
        if (push_num != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_num == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push_data1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/morse_code_decoder.sv =====
// Top level of the Morse code decoder: symbol buffer, table lookup, result queue.
// Depends on mcd_pkg and mcd_result_fifo.
`default_nettype none

// Decodes a stream of Morse text bytes into characters. Each input item is a
// byte on s_axis_tdata ('.' dot, ' ' end of code, '/' word gap, anything else a
// dash) or an end-of-line mark on s_axis_tlast. Every item is handled in the
// cycle it is accepted, so one item per clock is taken; an item yields zero,
// one or two results (end of line with a pending code gives the letter and then
// a newline with m_axis_tlast high). Results go through a four-entry queue and
// s_axis_tready drops while fewer than two free entries remain, so output
// stalls and two-result items are what lower the input rate. Codes longer than
// five symbols or with no table entry decode to '?'.

module morse_code_decoder #(
    parameter int MAX_SYMBOLS = mcd_pkg::MAX_SYMBOLS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Input stream
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  wire logic       s_axis_tlast,   // end_of_line
    // Result stream
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] character
    output logic            m_axis_tlast    // line_done
);

    // Saturation point of the symbol count
    localparam logic [3:0] SYM_LIMIT = 4'((MAX_SYMBOLS < 15) ? MAX_SYMBOLS : 15);

    logic [7:0]        pat_reg, pat_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              accept;
    logic [7:0]        looked_up;
    logic [1:0]        push_num;
    mcd_pkg::result_t  push_data0, push_data1;
    logic              room_for_two;
    mcd_pkg::result_t  out_data;

    assign s_axis_tready = room_for_two;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign looked_up     = mcd_pkg::lookup_code(pat_reg, cnt_reg);

    // Buffer update and result generation for the item being accepted
    always_comb begin
        pat_next   = pat_reg;
        cnt_next   = cnt_reg;
        push_num   = 2'd0;
        push_data0 = '{line_done: 1'b0, character: looked_up};
        push_data1 = '{line_done: 1'b1, character: mcd_pkg::CH_NL};
        if (accept) begin
            if (s_axis_tlast) begin
                // End of line: flush pending code, then newline
                if (cnt_reg != 4'd0) begin
                    push_num = 2'd2;
                end else begin
                    push_num   = 2'd1;
                    push_data0 = '{line_done: 1'b1, character: mcd_pkg::CH_NL};
                end
                pat_next = '0;
                cnt_next = '0;
            end else if (s_axis_tdata == mcd_pkg::CH_SPACE) begin
                if (cnt_reg != 4'd0) begin
                    push_num = 2'd1;
                    pat_next = '0;
                    cnt_next = '0;
                end
            end else if (s_axis_tdata == mcd_pkg::CH_SLASH) begin
                // Word gap keeps the pending code
                push_num   = 2'd1;
                push_data0 = '{line_done: 1'b0, character: mcd_pkg::CH_SPACE};
            end else if (cnt_reg < SYM_LIMIT) begin
                if (cnt_reg < 4'd8 && s_axis_tdata != mcd_pkg::CH_DOT) begin
                    pat_next = pat_reg | (8'd1 << cnt_reg[2:0]);
                end
                cnt_next = cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg <= '0;
            cnt_reg <= '0;
        end else begin
            pat_reg <= pat_next;
            cnt_reg <= cnt_next;
        end
    end

    // Result queue
    mcd_result_fifo u_result_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_num     (push_num),
        .push_data0   (push_data0),
        .push_data1   (push_data1),
        .room_for_two (room_for_two),
        .pop          (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_data     (out_data)
    );

    assign m_axis_tdata = out_data.character;
    assign m_axis_tlast = out_data.line_done;

endmodule

`default_nettype wire
